// ===== rtl/tfl_pkg.sv =====
// Package for the text stream line formatter: shared types, character codes,
// configuration register indexes and line-kind codes. No dependencies.
`default_nettype none

package tfl_pkg;

	// Character codes used by the formatter.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_HAT    = 8'h5E;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_LINE_END  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CARET_NOTATION = 3'd4;

	// Numbering modes.
	localparam logic [1:0] NUM_NONE = 2'd0;
	localparam logic [1:0] NUM_ALL  = 2'd1;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_NEWLINE = 2'd1,
		KIND_OTHER   = 2'd2
	} kind_t;

	typedef struct packed {
		logic       squeeze_blank;
		logic [1:0] number_mode;
		logic       mark_line_end;
		logic       show_tabs;
		logic       caret_notation;
	} cfg_t;

	// One classified request: which pieces the back end prints, in order.
	typedef struct packed {
		logic       num;
		logic       dollar;
		logic       meta;
		logic       hat;
		logic [7:0] chr;
	} desc_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_NUM,
		PH_TAB,
		PH_DOLLAR,
		PH_META_M,
		PH_META_DASH,
		PH_HAT,
		PH_CHAR
	} phase_t;

endpackage

`default_nettype wire

// ===== rtl/tfl_front.sv =====
// Front end of the line formatter: accepts raw bytes, tracks line state and
// the BCD line counter, and classifies each byte into a descriptor. Uses tfl_pkg.
`default_nettype none

module tfl_front
	import tfl_pkg::*;
#(
	parameter int unsigned NUMBER_DIGITS = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 in_byte,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output desc_t                           push_desc,
	output logic [4*NUMBER_DIGITS-1:0]      push_number
);

	localparam int unsigned NUM_W = 4 * NUMBER_DIGITS;

	kind_t            kind_q;
	logic [1:0]       blank_q;
	logic [NUM_W-1:0] number_q;

	logic             is_nl;
	logic             at_start;
	logic [1:0]       blank_d;
	logic             printing;
	logic             do_num;
	logic             accept;
	logic [NUMBER_DIGITS-1:0] nine;
	logic [NUM_W-1:0] bumped;
	logic [7:0]       low;

	assign is_nl    = (in_byte == CH_NL);
	assign at_start = (kind_q == KIND_START) || (kind_q == KIND_NEWLINE);

	always_comb begin
		blank_d = blank_q;
		if (cfg.squeeze_blank) begin
			if (is_nl && kind_q == KIND_NEWLINE) begin
				if (blank_q < 2'd2)
					blank_d = blank_q + 2'd1;
			end else begin
				blank_d = 2'd0;
			end
		end
	end

	assign printing = !(cfg.squeeze_blank && blank_d > 2'd1);
	assign do_num   = at_start && (cfg.number_mode != NUM_NONE) &&
		((cfg.number_mode == NUM_ALL) || !is_nl);

	// Each digit steps once all lower digits are nine or more; a nine wraps to zero.
	for (genvar i = 0; i < NUMBER_DIGITS; i++) begin : g_bump
		logic carry;
		assign nine[i] = (number_q[4*i +: 4] >= 4'd9);
		if (i == 0) begin : g_lsd
			assign carry = 1'b1;
		end else begin : g_upper
			assign carry = &nine[i-1:0];
		end
		assign bumped[4*i +: 4] = !carry ? number_q[4*i +: 4] :
			(nine[i] ? 4'd0 : number_q[4*i +: 4] + 4'd1);
	end

	// Character classification for the back end.
	assign low = cfg.caret_notation ? {1'b0, in_byte[6:0]} : in_byte;

	always_comb begin
		push_desc.num    = do_num;
		push_desc.dollar = cfg.mark_line_end && is_nl;
		push_desc.meta   = 1'b0;
		push_desc.hat    = 1'b0;
		push_desc.chr    = in_byte;
		if (cfg.show_tabs && in_byte == CH_TAB) begin
			push_desc.hat = 1'b1;
			push_desc.chr = CH_I;
		end else if (cfg.caret_notation) begin
			push_desc.meta = in_byte[7];
			priority if (low == CH_NL || low == CH_TAB ||
				(low >= CH_PRINT_LO && low <= CH_PRINT_HI)) begin
				push_desc.chr = low;
			end else if (low < CH_PRINT_LO) begin
				push_desc.hat = 1'b1;
				push_desc.chr = low + CTRL_OFFSET;
			end else begin
				push_desc.hat = 1'b1;
				push_desc.chr = CH_QMARK;
			end
		end
	end

	assign in_ready    = push_ready;
	assign push_valid  = in_valid && printing;
	assign push_number = number_q;
	assign accept      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_START;
			blank_q  <= 2'd0;
			number_q <= NUM_W'(1);
		end else if (accept) begin
			kind_q  <= is_nl ? KIND_NEWLINE : KIND_OTHER;
			blank_q <= blank_d;
			if (printing && do_num)
				number_q <= bumped;
		end
	end

	// Only a newline can ever be swallowed by blank-line squeezing.
	a_suppress_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !printing) |-> is_nl)
		else $error("non-newline byte suppressed");

endmodule

`default_nettype wire

// ===== rtl/tfl_queue.sv =====
// Two-entry queue of classified requests between front and back end of the
// line formatter. Uses tfl_pkg for the descriptor type.
`default_nettype none

module tfl_queue
	import tfl_pkg::*;
#(
	parameter int unsigned NUM_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire desc_t            push_desc,
	input  wire logic [NUM_W-1:0] push_number,
	output logic                  head_valid,
	input  wire logic             pop,
	output desc_t                 head_desc,
	output logic [NUM_W-1:0]      head_number
);

	desc_t            desc_q   [2];
	logic [NUM_W-1:0] number_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready  = (count_q != 2'd2);
	assign head_valid  = (count_q != 2'd0);
	assign head_desc   = desc_q[rd_q];
	assign head_number = number_q[rd_q];
	assign do_push     = push_valid && push_ready;
	assign do_pop      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			desc_q[wr_q]   <= push_desc;
			number_q[wr_q] <= push_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/tfl_back.sv =====
// Back end of the line formatter: walks each queued descriptor and emits its
// output bytes one per cycle unless stalled, from a register. Uses tfl_pkg.
`default_nettype none

module tfl_back
	import tfl_pkg::*;
#(
	parameter int unsigned NUMBER_DIGITS = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire desc_t                      head_desc,
	input  wire logic [4*NUMBER_DIGITS-1:0] head_number,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      out_byte,
	output logic                            last
);

	localparam int unsigned DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	phase_t       phase_q;
	phase_t       phase_d;
	phase_t       cur;
	phase_t       after_tab;
	phase_t       after_dollar;
	phase_t       after_meta;
	logic [DW-1:0] digit_q;
	logic [DW-1:0] digit_d;
	logic [DW-1:0] idx;
	logic          load;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;
	logic [7:0]    byte_d;
	logic [NUMBER_DIGITS-1:0] zero;
	logic [NUMBER_DIGITS-1:0] lead;
	logic [3:0]    raw_digit;
	logic [3:0]    digit_val;

	// Leading zero digits print as spaces, apart from the lowest digit.
	for (genvar i = 0; i < NUMBER_DIGITS; i++) begin : g_lead
		assign zero[i] = (head_number[4*i +: 4] == 4'd0);
		if (i == NUMBER_DIGITS - 1) begin : g_top
			assign lead[i] = 1'b1;
		end else begin : g_rest
			assign lead[i] = &zero[NUMBER_DIGITS-1:i+1];
		end
	end

	assign after_meta   = head_desc.hat ? PH_HAT : PH_CHAR;
	assign after_dollar = head_desc.meta ? PH_META_M : after_meta;
	assign after_tab    = head_desc.dollar ? PH_DOLLAR : after_dollar;

	always_comb begin
		if (phase_q == PH_START) begin
			cur = head_desc.num ? PH_NUM : after_tab;
			idx = DW'(NUMBER_DIGITS - 1);
		end else begin
			cur = phase_q;
			idx = digit_q;
		end
	end

	assign load = head_valid && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		phase_d = phase_q;
		digit_d = digit_q;
		if (load) begin
			unique case (cur)
				PH_NUM: begin
					if (idx == DW'(0)) begin
						phase_d = PH_TAB;
					end else begin
						phase_d = PH_NUM;
						digit_d = idx - DW'(1);
					end
				end
				PH_TAB:       phase_d = after_tab;
				PH_DOLLAR:    phase_d = after_dollar;
				PH_META_M:    phase_d = PH_META_DASH;
				PH_META_DASH: phase_d = after_meta;
				PH_HAT:       phase_d = PH_CHAR;
				PH_CHAR:      phase_d = PH_START;
				default:      phase_d = PH_START;
			endcase
		end
	end

	assign raw_digit = head_number[4*idx +: 4];
	assign digit_val = (raw_digit > 4'd9) ? 4'd9 : raw_digit;

	// Outputs.
	always_comb begin
		unique case (cur)
			PH_NUM: begin
				if (lead[idx] && digit_val == 4'd0 && idx != DW'(0))
					byte_d = CH_SPACE;
				else
					byte_d = CH_ZERO + {4'd0, digit_val};
			end
			PH_TAB:       byte_d = CH_TAB;
			PH_DOLLAR:    byte_d = CH_DOLLAR;
			PH_META_M:    byte_d = CH_M;
			PH_META_DASH: byte_d = CH_DASH;
			PH_HAT:       byte_d = CH_HAT;
			PH_CHAR:      byte_d = head_desc.chr;
			default:      byte_d = head_desc.chr;
		endcase
		pop = load && (cur == PH_CHAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			digit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			digit_q <= digit_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			last_q     <= pop;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// Midway through a request the queue head must stay put.
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |-> head_valid)
		else $error("queue head lost during expansion");

	a_pop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (phase_q == PH_START))
		else $error("sequencer not restarted after final byte");

endmodule

`default_nettype wire

// ===== rtl/text_stream_line_formatter.sv =====
// Top level of the text stream line formatter: configuration registers and
// the front end, request queue and back end. Uses tfl_pkg, tfl_front,
// tfl_queue and tfl_back.
`default_nettype none

// The formatter turns a stream of raw text bytes into formatted bytes; its
// output sequencer sets the throughput at one output byte per cycle while
// out_ready is high. An input byte expanding to up to NUMBER_DIGITS + 5
// output bytes occupies the sequencer, so ordinary bytes flow at one per
// cycle and longer expansions stall the input once the two-entry request
// queue between front and back end is full. A byte removed by blank-line
// squeezing gives no output. The last flag marks the final output byte of
// each input byte. Configuration must be written only when idle (unchecked).
module text_stream_line_formatter
	import tfl_pkg::*;
#(
	parameter int unsigned NUMBER_DIGITS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            in_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last
);

	localparam int unsigned NUM_W = 4 * NUMBER_DIGITS;

	cfg_t             cfg_q;
	logic             push_valid;
	logic             push_ready;
	desc_t            push_desc;
	logic [NUM_W-1:0] push_number;
	logic             head_valid;
	logic             pop;
	desc_t            head_desc;
	logic [NUM_W-1:0] head_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SQUEEZE_BLANK:  cfg_q.squeeze_blank  <= cfg_data[0];
				CFG_NUMBER_MODE:    cfg_q.number_mode    <= cfg_data;
				CFG_MARK_LINE_END:  cfg_q.mark_line_end  <= cfg_data[0];
				CFG_SHOW_TABS:      cfg_q.show_tabs      <= cfg_data[0];
				CFG_CARET_NOTATION: cfg_q.caret_notation <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tfl_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.push_number(push_number)
	);

	tfl_queue #(
		.NUM_W(NUM_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.push_number(push_number),
		.head_valid (head_valid),
		.pop        (pop),
		.head_desc  (head_desc),
		.head_number(head_number)
	);

	tfl_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.head_number(head_number),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule

`default_nettype wire
